// ===== hdl/sps_pkg.sv =====
package sps_pkg;

   localparam int POS_W = 12;
   localparam int TARGET_W = 16;
   localparam int PHASE_W = 3;
   localparam int COIL_W = 4;
   localparam int PRESCALE_W = 5;
   localparam int SPEED_W = 2;

   localparam int STEP_TENTHS = 3;
   localparam logic [POS_W-1:0] MAX_TENTHS_RESET = 12'd3150;
   localparam logic [PHASE_W-1:0] PHASE_LAST = 3'd5;

   // Rounding down to a step multiple uses a reciprocal multiply. The shift is
   // wide enough that the truncated quotient is exact for every 12-bit value.
   localparam int RECIP_SHIFT = 20;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int RECIP_MULT = (2 ** RECIP_SHIFT + STEP_TENTHS - 1) / STEP_TENTHS;
   localparam int PROD_W = POS_W + RECIP_W;
   localparam int STEP_W = 4;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_MOVE    = 2'd1,
      KIND_JOG     = 2'd2,
      KIND_RELEASE = 2'd3
   } kind_type;

   function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pattern;
      unique case (phase)
         3'd0: pattern = 4'h9;
         3'd1: pattern = 4'h1;
         3'd2: pattern = 4'h7;
         3'd3: pattern = 4'h6;
         3'd4: pattern = 4'hE;
         3'd5: pattern = 4'h8;
         default: pattern = 4'h0;
      endcase
      return pattern;
   endfunction

   function automatic logic [PRESCALE_W-1:0] prescale_for(input logic [SPEED_W-1:0] speed);
      logic [PRESCALE_W-1:0] code;
      unique case (speed)
         2'd0: code = 5'd2;
         2'd1: code = 5'd4;
         2'd2: code = 5'd8;
         2'd3: code = 5'd16;
         default: code = 5'd2;
      endcase
      return code;
   endfunction

   function automatic logic [PHASE_W-1:0] next_phase(input logic [PHASE_W-1:0] phase,
                                                     input logic cw);
      logic [PHASE_W-1:0] result;
      if (cw) begin
         result = (phase >= PHASE_LAST) ? '0 : phase + 3'd1;
      end else begin
         result = (phase == '0 || phase > PHASE_LAST) ? PHASE_LAST : phase - 3'd1;
      end
      return result;
   endfunction

endpackage

// ===== hdl/sps_target_round.sv =====
module sps_target_round (
   input  logic [sps_pkg::TARGET_W-1:0] target_tenths,
   input  logic [sps_pkg::POS_W-1:0]    max_tenths,
   output logic [sps_pkg::POS_W-1:0]    step_count
);

   logic [sps_pkg::POS_W-1:0]  clamped;
   logic [sps_pkg::PROD_W-1:0] product;

   always_comb begin
      if (target_tenths > {{(sps_pkg::TARGET_W - sps_pkg::POS_W){1'b0}}, max_tenths}) begin
         clamped = max_tenths;
      end else begin
         clamped = target_tenths[sps_pkg::POS_W-1:0];
      end
      product = (sps_pkg::PROD_W)'(clamped)
              * (sps_pkg::PROD_W)'(sps_pkg::RECIP_MULT);
      step_count = product[sps_pkg::RECIP_SHIFT +: sps_pkg::POS_W];
   end

endmodule

// ===== hdl/stepper_position_sequencer_top.sv =====
// Channel | Direction | Handshake         | Payload
// req     | in        | req_tvalid/tready | tdata: target, speed, direction; tuser: kind
// rsp     | out       | rsp_tvalid/tready | tdata: coils, running, position, prescale, arrived
// csr     | in        | csr_valid/ready   | csr_wdata: max_tenths
//
// One item per cycle is taken unless a stall holds stage one; each result is registered.
// The first stage clamps the target and multiplies by the step reciprocal; the
// second stage rounds the target and updates the phase, position and move state.
// Reset is synchronous and needs no clearing pass; the block is ready right away.
// A stalled result holds both stages, and input is still taken while stage one is free.
module stepper_position_sequencer_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // target_tenths[15:0], speed[17:16], direction[18], zero
   input  logic [1:0]  req_tuser,  // kind[1:0]

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // coils[3:0], running[4], position_tenths[16:5],
                                   // prescale[21:17], arrived[22], zero

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [11:0] csr_wdata
);

   localparam int PW = sps_pkg::POS_W;

   logic [PW-1:0] max_tenths_ff;

   logic                          s1_valid_ff, s1_valid_in;
   sps_pkg::kind_type             s1_kind_ff;
   logic [PW-1:0]                 s1_steps_ff;
   logic [sps_pkg::SPEED_W-1:0]   s1_speed_ff;
   logic                          s1_dir_ff;
   logic [PW-1:0]                 steps;

   logic [sps_pkg::PHASE_W-1:0]    phase_ff, phase_in;
   logic [PW-1:0]                  position_ff, position_in;
   logic [PW-1:0]                  goal_ff, goal_in;
   logic                           going_up_ff, going_up_in;
   logic                           moving_ff, moving_in;
   logic [sps_pkg::COIL_W-1:0]     coil_ff, coil_in;
   logic [sps_pkg::PRESCALE_W-1:0] prescale_ff, prescale_in;
   logic                           arrived_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [23:0]                    rsp_data_ff;

   logic                           advance;
   logic                           req_take;
   logic                           commit;
   logic [PW-1:0]                  rounded;
   logic [PW+sps_pkg::STEP_W-1:0]  rounded_full;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_tenths_ff <= sps_pkg::MAX_TENTHS_RESET;
      end else if (csr_valid && csr_ready) begin
         max_tenths_ff <= csr_wdata;
      end
   end

   sps_target_round u_round (
      .target_tenths (req_tdata[15:0]),
      .max_tenths    (max_tenths_ff),
      .step_count    (steps)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign commit     = s1_valid_ff && advance;

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= sps_pkg::kind_type'(req_tuser);
         s1_steps_ff <= steps;
         s1_speed_ff <= req_tdata[17:16];
         s1_dir_ff   <= req_tdata[18];
      end
   end

   assign rounded_full = (PW + sps_pkg::STEP_W)'(s1_steps_ff)
                       * (PW + sps_pkg::STEP_W)'(sps_pkg::STEP_TENTHS);
   assign rounded      = rounded_full[PW-1:0];

   always_comb begin
      phase_in    = phase_ff;
      position_in = position_ff;
      goal_in     = goal_ff;
      going_up_in = going_up_ff;
      moving_in   = moving_ff;
      coil_in     = coil_ff;
      prescale_in = prescale_ff;
      arrived_in  = 1'b0;
      unique case (s1_kind_ff)
         sps_pkg::KIND_TICK: begin
            if (moving_ff) begin
               phase_in = sps_pkg::next_phase(phase_ff, going_up_ff);
               coil_in  = sps_pkg::coil_pattern(phase_in);
               if (going_up_ff) begin
                  position_in = position_ff + PW'(sps_pkg::STEP_TENTHS);
               end else begin
                  position_in = position_ff - PW'(sps_pkg::STEP_TENTHS);
               end
               if (position_in == goal_ff) begin
                  moving_in  = 1'b0;
                  coil_in    = '0;
                  arrived_in = 1'b1;
               end
            end
         end
         sps_pkg::KIND_MOVE: begin
            prescale_in = sps_pkg::prescale_for(s1_speed_ff);
            if (rounded != position_ff) begin
               going_up_in = rounded > position_ff;
               goal_in     = rounded;
               moving_in   = 1'b1;
            end
         end
         sps_pkg::KIND_JOG: begin
            phase_in = sps_pkg::next_phase(phase_ff, s1_dir_ff);
            coil_in  = sps_pkg::coil_pattern(phase_in);
         end
         sps_pkg::KIND_RELEASE: begin
            coil_in = '0;
         end
         default: begin
            coil_in = coil_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         position_ff <= '0;
         goal_ff     <= '0;
         going_up_ff <= 1'b1;
         moving_ff   <= 1'b0;
         coil_ff     <= '0;
         prescale_ff <= '0;
      end else if (commit) begin
         phase_ff    <= phase_in;
         position_ff <= position_in;
         goal_ff     <= goal_in;
         going_up_ff <= going_up_in;
         moving_ff   <= moving_in;
         coil_ff     <= coil_in;
         prescale_ff <= prescale_in;
      end
   end

   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_data_ff <= {1'b0, arrived_in, prescale_in, position_in, moving_in, coil_in};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_arrived_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[22]) |-> (!rsp_tdata[4] && rsp_tdata[3:0] == 4'h0))
      else $error("arrived result still shows a running move or driven coils");

   a_goal_apart: assert property (@(posedge clock) disable iff (reset)
      moving_ff |-> (goal_ff != position_ff))
      else $error("move is running while already at its goal");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= sps_pkg::PHASE_LAST)
      else $error("phase index left the six-phase range");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !commit |=> ($stable(position_ff) && $stable(moving_ff) && $stable(phase_ff)))
      else $error("state changed without an item being committed");

   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

endmodule
